// File: rtl/core/scbp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the size-class buffer pool
package scbp_pkg;

    localparam int SIZE_CLASSES       = 18;
    localparam int LINK_DEPTH         = 32768;
    localparam int POOL_BYTES         = 1048576;
    localparam int LARGE_HEADER_BYTES = 16;
    localparam int ADDR_SPACE         = 1048576;
    localparam int POOL_LIMIT         = (POOL_BYTES < ADDR_SPACE) ? POOL_BYTES : ADDR_SPACE;

    localparam int SIZE_W = 24;
    localparam int ADDR_W = 20;
    localparam int CLS_W  = 5;
    localparam int CNT_W  = 32;
    localparam int BLK_W  = 15;
    localparam int CAP_W  = 21;
    localparam int MSS_W  = 15;
    localparam int HEAD_W = 16;

    localparam logic [MSS_W-1:0] CLASS_LIMIT = MSS_W'(16384);
    localparam logic [CLS_W-1:0] CLASS_LARGE = CLS_W'(18);

    // configuration register indexes
    localparam logic CFG_MAX_SMALL = 1'b0;
    localparam logic CFG_POOL_CAP  = 1'b1;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LARGE = 2'd1,
        ST_OOM   = 2'd2
    } t_status;

    typedef struct packed {
        logic              is_large;
        logic [CLS_W-1:0]  cls;
        logic [SIZE_W-1:0] grant;
    } t_class_info;

    // packed so that status lands in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]  total;
        logic [CNT_W-1:0]  used;
        logic [SIZE_W-1:0] granted;
        logic [CLS_W-1:0]  cls;
        logic [ADDR_W-1:0] address;
        t_status           status;
    } t_result;

endpackage

// File: rtl/core/scbp_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read
module scbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/scbp_classify.sv
`timescale 1ns / 1ps
// maps a request size to its size class and rounded grant
module scbp_classify
    import scbp_pkg::*;
(
    input  logic [SIZE_W-1:0] i_size,
    input  logic [MSS_W-1:0]  i_max_small,
    output t_class_info       o_info
);

    logic [MSS_W-1:0] w_thresh;
    logic             w_large;
    logic [MSS_W-1:0] w_len;
    logic [15:0]      w_sum;
    logic [CLS_W-1:0] w_idx;
    logic [SIZE_W-1:0] w_grant;

    assign w_thresh = (i_max_small > CLASS_LIMIT) ? CLASS_LIMIT : i_max_small;
    assign w_large  = i_size > SIZE_W'(w_thresh);
    // zero counts as one byte
    assign w_len    = (i_size == '0) ? MSS_W'(1) : i_size[MSS_W-1:0];

    always_comb begin
        w_sum   = '0;
        w_idx   = '0;
        w_grant = '0;
        priority if (w_len <= MSS_W'(224)) begin
            w_sum   = {1'b0, w_len} + 16'd31;
            w_idx   = CLS_W'(w_sum >> 5);
            w_grant = {8'd0, w_sum[15:5], 5'd0};
        end else if (w_len <= MSS_W'(768)) begin
            w_sum   = {1'b0, w_len} + 16'd255;
            w_idx   = CLS_W'(w_sum >> 8) + CLS_W'(7);
            w_grant = {8'd0, w_sum[15:8], 8'd0};
        end else if (w_len <= MSS_W'(3072)) begin
            w_sum   = {1'b0, w_len} + 16'd1023;
            w_idx   = CLS_W'(w_sum >> 10) + CLS_W'(10);
            w_grant = {8'd0, w_sum[15:10], 10'd0};
        end else begin
            w_sum   = {1'b0, w_len} + 16'd4095;
            w_idx   = CLS_W'(w_sum >> 12) + CLS_W'(13);
            w_grant = {8'd0, w_sum[15:12], 12'd0};
        end
    end

    always_comb begin
        o_info.is_large = w_large;
        o_info.cls      = w_large ? CLASS_LARGE : w_idx;
        o_info.grant    = w_large ? i_size : w_grant;
    end

endmodule

// File: rtl/core/size_class_buffer_pool_top.sv
`timescale 1ns / 1ps
// Size-class buffer pool: a request enters on the slave stream, is classed, and its result
// leaves through a one-entry output register. One request is worked on at a time. A free,
// a fresh carve, a large external request and an out-of-memory answer end in the head state,
// where a free writes the new list head back; an allocate that pops a free list also passes
// the link state, since the next link must be read from the link memory before the head is
// rewritten. A new request is taken as soon as the previous result sits in the output
// register; if that register is still full at completion the block holds the result until
// the master side takes it. After reset all lists are empty at once (each head entry has a
// written flag), so no clearing pass is run. Configuration is taken every cycle.
module size_class_buffer_pool_top
    import scbp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration write channel
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [CAP_W-1:0] i_cfg_data,
    // request stream
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [47:0]    i_s_tdata,   // req_size[23:0], block_address[43:24], zero[47:44]
    input  logic           i_s_tuser,   // req_type[0]
    // result stream
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [119:0]   o_m_tdata    // status[1:0], address[21:2], size_class[26:22],
                                        // granted_bytes[50:27], used_bytes[82:51],
                                        // total_bytes[114:83], zero[119:115]
);

    localparam int HEAD_AW = $clog2(SIZE_CLASSES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_LINK,
        S_HOLD
    } t_state;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ADD,
        CNT_SUB
    } t_cnt_op;

    typedef struct packed {
        t_req_type   req_type;
        t_class_info info;
        logic [BLK_W-1:0] blk;
    } t_req;

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [SIZE_W:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W + 1)'(b);
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub(logic [CNT_W-1:0] a, logic [SIZE_W:0] b);
        return (CNT_W'(b) >= a) ? '0 : a - CNT_W'(b);
    endfunction

    t_state             r_state, n_state;
    logic [MSS_W-1:0]   r_max_small, n_max_small;
    logic [CAP_W-1:0]   r_pool_cap, n_pool_cap;
    logic [CAP_W-1:0]   r_carve, n_carve;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [SIZE_CLASSES-1:0] r_head_wr, n_head_wr;
    logic               r_head_known, n_head_known;
    t_req               r_req, n_req;
    logic [BLK_W-1:0]   r_pop_blk, n_pop_blk;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;
    t_result            r_res, n_res;

    t_class_info        w_info;
    logic               w_acc;
    logic               w_out_free;
    logic [HEAD_W-1:0]  w_head_rdata;
    logic [HEAD_W-1:0]  w_link_rdata;
    logic [HEAD_W-1:0]  w_head_eff;
    logic [CAP_W-1:0]   w_limit;
    logic [CAP_W:0]     w_carve_sum;
    logic [SIZE_W:0]    w_large_amt;

    logic               head_we;
    logic [HEAD_W-1:0]  head_wdata;
    logic               link_we;
    logic               link_re;
    logic [BLK_W-1:0]   link_raddr;
    logic               res_done;
    logic               out_load;
    t_status            res_status;
    logic [ADDR_W-1:0]  res_addr;
    t_cnt_op            used_op, total_op;
    logic [SIZE_W:0]    used_amt, total_amt;
    t_result            res;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_acc       = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;

    scbp_classify u_classify (
        .i_size      (i_s_tdata[SIZE_W-1:0]),
        .i_max_small (r_max_small),
        .o_info      (w_info)
    );

    scbp_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (SIZE_CLASSES)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (HEAD_AW'(r_req.info.cls)),
        .i_wdata (head_wdata),
        .i_re    (w_acc && !w_info.is_large),
        .i_raddr (HEAD_AW'(w_info.cls)),
        .o_rdata (w_head_rdata)
    );

    scbp_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_req.blk),
        .i_wdata (w_head_eff),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (w_link_rdata)
    );

    // a head entry never written reads as an empty list
    assign w_head_eff  = r_head_known ? w_head_rdata : '0;
    assign w_limit     = (r_pool_cap > CAP_W'(POOL_LIMIT)) ? CAP_W'(POOL_LIMIT) : r_pool_cap;
    assign w_carve_sum = {1'b0, r_carve} + (CAP_W + 1)'(r_req.info.grant);
    assign w_large_amt = {1'b0, r_req.info.grant} + (SIZE_W + 1)'(LARGE_HEADER_BYTES);
    assign link_raddr  = w_head_eff[BLK_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_carve     = r_carve;
        n_pop_blk   = r_pop_blk;
        head_we     = 1'b0;
        head_wdata  = '0;
        link_we     = 1'b0;
        link_re     = 1'b0;
        res_done    = 1'b0;
        res_status  = ST_OK;
        res_addr    = '0;
        used_op     = CNT_HOLD;
        used_amt    = (SIZE_W + 1)'(r_req.info.grant);
        total_op    = CNT_HOLD;
        total_amt   = (SIZE_W + 1)'(r_req.info.grant);

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                priority if (r_req.info.is_large) begin
                    res_done   = 1'b1;
                    res_status = ST_LARGE;
                    used_amt   = w_large_amt;
                    total_amt  = w_large_amt;
                    used_op    = (r_req.req_type == REQ_FREE) ? CNT_SUB : CNT_ADD;
                    total_op   = used_op;
                end else if (r_req.req_type == REQ_FREE) begin
                    // push: old head becomes the block's link
                    res_done   = 1'b1;
                    link_we    = 1'b1;
                    head_we    = 1'b1;
                    head_wdata = {1'b1, r_req.blk};
                    used_op    = CNT_SUB;
                end else if (w_head_eff[HEAD_W-1]) begin
                    link_re    = 1'b1;
                    n_pop_blk  = w_head_eff[BLK_W-1:0];
                    n_state    = S_LINK;
                end else if (w_carve_sum > (CAP_W + 1)'(w_limit)) begin
                    res_done   = 1'b1;
                    res_status = ST_OOM;
                end else begin
                    res_done   = 1'b1;
                    res_addr   = r_carve[ADDR_W-1:0];
                    n_carve    = w_carve_sum[CAP_W-1:0];
                    used_op    = CNT_ADD;
                    total_op   = CNT_ADD;
                end
            end
            S_LINK: begin
                res_done   = 1'b1;
                head_we    = 1'b1;
                head_wdata = w_link_rdata;
                res_addr   = {r_pop_blk, 5'd0};
                used_op    = CNT_ADD;
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase

        if (res_done) begin
            n_state = w_out_free ? S_IDLE : S_HOLD;
        end

        case (used_op)
            CNT_ADD: n_used = sat_add(r_used, used_amt);
            CNT_SUB: n_used = sat_sub(r_used, used_amt);
            default: n_used = r_used;
        endcase
        case (total_op)
            CNT_ADD: n_total = sat_add(r_total, total_amt);
            CNT_SUB: n_total = sat_sub(r_total, total_amt);
            default: n_total = r_total;
        endcase

        res.total   = n_total;
        res.used    = n_used;
        res.granted = r_req.info.grant;
        res.cls     = r_req.info.cls;
        res.address = res_addr;
        res.status  = res_status;

        out_load    = w_out_free && (res_done || (r_state == S_HOLD));
        n_res       = res_done ? res : r_res;
        n_out       = out_load ? n_res : r_out;
        priority if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        n_head_wr = r_head_wr;
        if (head_we) begin
            n_head_wr[HEAD_AW'(r_req.info.cls)] = 1'b1;
        end

        n_req        = r_req;
        n_head_known = r_head_known;
        if (w_acc) begin
            n_req.req_type = t_req_type'(i_s_tuser);
            n_req.info     = w_info;
            n_req.blk      = i_s_tdata[SIZE_W+ADDR_W-1:SIZE_W+5];
            n_head_known   = !w_info.is_large && r_head_wr[HEAD_AW'(w_info.cls)];
        end

        n_max_small = r_max_small;
        n_pool_cap  = r_pool_cap;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_SMALL: n_max_small = i_cfg_data[MSS_W-1:0];
                CFG_POOL_CAP:  n_pool_cap  = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_head_known <= n_head_known;
        r_pop_blk    <= n_pop_blk;
        r_res        <= n_res;
        r_out        <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_small <= MSS_W'(16384);
            r_pool_cap  <= CAP_W'(1048576);
            r_carve     <= '0;
            r_used      <= '0;
            r_total     <= '0;
            r_head_wr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max_small <= n_max_small;
            r_pool_cap  <= n_pool_cap;
            r_carve     <= n_carve;
            r_used      <= n_used;
            r_total     <= n_total;
            r_head_wr   <= n_head_wr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out};

    // the bump pointer never passes the pool limit
    a_carve_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_carve <= CAP_W'(POOL_LIMIT))
        else $error("carve pointer beyond pool limit");

    // large requests never touch the class heads
    a_head_we_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_we |-> !r_req.info.is_large)
        else $error("head write on a large request");

    // after a result moves to the output register the block is ready again
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == S_IDLE))
        else $error("not idle after result load");

    // a pop reads the link of a valid head only
    a_link_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        link_re |-> (r_head_known && w_head_rdata[HEAD_W-1] && !r_req.info.is_large))
        else $error("link read without a valid head");

endmodule
